// ----- design/swt_pkg.sv -----
`default_nettype none

package swt_pkg;

   // Token kinds carried on the result channel
   typedef enum logic [2:0] {
      KIND_CHAR     = 3'd0,
      KIND_WORD_END = 3'd1,
      KIND_BLANK    = 3'd2,
      KIND_GREATER  = 3'd3,
      KIND_LESS     = 3'd4,
      KIND_PIPE     = 3'd5,
      KIND_EOL      = 3'd6
   } kind_type;

   // Scan modes of the tokenizer
   typedef enum logic [2:0] {
      MODE_START   = 3'd0,
      MODE_BLANK   = 3'd1,
      MODE_WORD    = 3'd2,
      MODE_DQ      = 3'd3,
      MODE_SQ      = 3'd4,
      MODE_WORD_BS = 3'd5,
      MODE_DQ_BS   = 3'd6,
      MODE_SQ_BS   = 3'd7
   } mode_type;

   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   localparam int MAX_RESULTS     = 3;
   localparam int SWT_QUEUE_DEPTH = 4;

   // One result
   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
   } res_type;

   // All results caused by one input item
   typedef struct packed {
      logic [1:0]                      count;
      res_type [MAX_RESULTS-1:0]       res;
   } bundle_type;

   // Queue status used for the request stall and by the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- design/swt_front.sv -----
`default_nettype none

module swt_front
   import swt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_char,
   input  wire logic       line_end,
   output      logic       push,
   output      bundle_type push_bundle
);

   typedef struct packed {
      logic     emit;
      kind_type kind;
      mode_type mode;
   } start_type;

   mode_type   mode_ff;
   mode_type   mode_in;
   bundle_type bnd;
   start_type  st;

   function automatic logic is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
             c == 8'h0C || c == 8'h0D;
   endfunction

   function automatic bundle_type put(bundle_type b, kind_type k, logic [7:0] c);
      bundle_type r;
      r = b;
      if (b.count != 2'd3) begin
         r.res[b.count] = '{kind: k, ch: c};
         r.count        = b.count + 2'd1;
      end
      return r;
   endfunction

   // Character seen at token start; blank handled by caller where needed
   function automatic start_type at_start(logic [7:0] c);
      start_type s;
      s = '{emit: 1'b0, kind: KIND_CHAR, mode: MODE_START};
      if (is_blank(c)) begin
         s.mode = MODE_BLANK;
      end else if (c == CH_GREATER) begin
         s.emit = 1'b1;
         s.kind = KIND_GREATER;
      end else if (c == CH_LESS) begin
         s.emit = 1'b1;
         s.kind = KIND_LESS;
      end else if (c == CH_PIPE) begin
         s.emit = 1'b1;
         s.kind = KIND_PIPE;
      end else if (c == CH_DQUOTE) begin
         s.mode = MODE_DQ;
      end else if (c == CH_SQUOTE) begin
         s.mode = MODE_SQ;
      end else if (c == CH_BSLASH) begin
         s.mode = MODE_WORD_BS;
      end else begin
         s.emit = 1'b1;
         s.mode = MODE_WORD;
      end
      return s;
   endfunction

   always_comb begin
      bnd     = '0;
      mode_in = mode_ff;
      st      = at_start(in_char);
      if (line_end) begin
         unique case (mode_ff)
            MODE_BLANK: begin
               bnd     = put(bnd, KIND_BLANK, 8'h00);
               bnd     = put(bnd, KIND_EOL, 8'h00);
               mode_in = MODE_START;
            end
            MODE_WORD: begin
               bnd     = put(bnd, KIND_WORD_END, 8'h00);
               bnd     = put(bnd, KIND_EOL, 8'h00);
               mode_in = MODE_START;
            end
            MODE_WORD_BS: begin
               bnd     = put(bnd, KIND_CHAR, CH_BSLASH);
               bnd     = put(bnd, KIND_WORD_END, 8'h00);
               bnd     = put(bnd, KIND_EOL, 8'h00);
               mode_in = MODE_START;
            end
            MODE_DQ, MODE_SQ: begin
               bnd = put(bnd, KIND_CHAR, CH_NEWLINE);
            end
            MODE_DQ_BS: begin
               bnd     = put(bnd, KIND_CHAR, CH_BSLASH);
               bnd     = put(bnd, KIND_CHAR, CH_NEWLINE);
               mode_in = MODE_DQ;
            end
            MODE_SQ_BS: begin
               bnd     = put(bnd, KIND_CHAR, CH_BSLASH);
               bnd     = put(bnd, KIND_CHAR, CH_NEWLINE);
               mode_in = MODE_SQ;
            end
            default: begin
               bnd     = put(bnd, KIND_EOL, 8'h00);
               mode_in = MODE_START;
            end
         endcase
      end else begin
         unique case (mode_ff)
            MODE_START, MODE_BLANK: begin
               if (!(mode_ff == MODE_BLANK && is_blank(in_char))) begin
                  if (mode_ff == MODE_BLANK) begin
                     bnd = put(bnd, KIND_BLANK, 8'h00);
                  end
                  if (st.emit) begin
                     bnd = put(bnd, st.kind, (st.kind == KIND_CHAR) ? in_char : 8'h00);
                  end
                  mode_in = st.mode;
               end
            end
            MODE_WORD: begin
               if (is_blank(in_char)) begin
                  bnd     = put(bnd, KIND_WORD_END, 8'h00);
                  mode_in = MODE_BLANK;
               end else if (in_char == CH_PIPE) begin
                  bnd     = put(bnd, KIND_WORD_END, 8'h00);
                  bnd     = put(bnd, KIND_PIPE, 8'h00);
                  mode_in = MODE_START;
               end else if (in_char == CH_DQUOTE) begin
                  mode_in = MODE_DQ;
               end else if (in_char == CH_SQUOTE) begin
                  mode_in = MODE_SQ;
               end else if (in_char == CH_BSLASH) begin
                  mode_in = MODE_WORD_BS;
               end else begin
                  bnd = put(bnd, KIND_CHAR, in_char);
               end
            end
            MODE_DQ: begin
               if (in_char == CH_DQUOTE) begin
                  mode_in = MODE_WORD;
               end else if (in_char == CH_BSLASH) begin
                  mode_in = MODE_DQ_BS;
               end else begin
                  bnd = put(bnd, KIND_CHAR, in_char);
               end
            end
            MODE_SQ: begin
               if (in_char == CH_SQUOTE) begin
                  mode_in = MODE_WORD;
               end else if (in_char == CH_BSLASH) begin
                  mode_in = MODE_SQ_BS;
               end else begin
                  bnd = put(bnd, KIND_CHAR, in_char);
               end
            end
            MODE_WORD_BS: begin
               if (!(in_char == CH_BSLASH || in_char == CH_DQUOTE ||
                     in_char == CH_SQUOTE)) begin
                  bnd = put(bnd, KIND_CHAR, CH_BSLASH);
               end
               bnd     = put(bnd, KIND_CHAR, in_char);
               mode_in = MODE_WORD;
            end
            MODE_DQ_BS: begin
               if (!(in_char == CH_BSLASH || in_char == CH_DQUOTE)) begin
                  bnd = put(bnd, KIND_CHAR, CH_BSLASH);
               end
               bnd     = put(bnd, KIND_CHAR, in_char);
               mode_in = MODE_DQ;
            end
            MODE_SQ_BS: begin
               if (!(in_char == CH_BSLASH || in_char == CH_SQUOTE)) begin
                  bnd = put(bnd, KIND_CHAR, CH_BSLASH);
               end
               bnd     = put(bnd, KIND_CHAR, in_char);
               mode_in = MODE_SQ;
            end
            default: begin
               mode_in = MODE_START;
            end
         endcase
      end
   end

   assign push        = accept && (bnd.count != 2'd0);
   assign push_bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/swt_queue.sv -----
`default_nettype none

module swt_queue
   import swt_pkg::*;
#(
   parameter int DEPTH = SWT_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_bundle,
   input  wire logic       pop,
   output      bundle_type head_bundle,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_bundle  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/swt_back.sv -----
`default_nettype none

module swt_back
   import swt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bundle_type       head_bundle,
   input  wire queue_status_type status,
   output      logic             pop,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic [2:0]       rsp_token_kind,
   output      logic [7:0]       rsp_out_char,
   output      logic             rsp_last
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   kind_type   kind_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       load;
   logic       at_end;
   res_type    cur;

   always_comb begin
      load     = !status.empty && (!valid_ff || !rsp_stall);
      cur      = head_bundle.res[idx_ff];
      at_end   = (idx_ff == head_bundle.count - 2'd1);
      pop      = load && at_end;
      idx_in   = idx_ff;
      if (load) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= cur.kind;
         char_ff <= cur.ch;
         last_ff <= at_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_token_kind = kind_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ----- design/shell_word_tokenizer.sv -----
`default_nettype none

// Streaming shell command-line tokenizer. Each request item carries one
// character, or an end-of-line mark when req_line_end is set, and causes zero
// to three response items: word characters with quotes removed and with a
// backslash dropped where it escapes a quote or backslash, and token ends for
// word, blank run, '>', '<', pipe and end of line; rsp_last flags the final
// response of each request. The front end takes one request per clock while
// req_stall is low, updates the scan mode and writes that request's responses
// as one entry into a bundle queue of QUEUE_DEPTH entries; the back end drains
// the queue into a registered output, one response per clock while rsp_stall
// is low. The back end sends a bundle's responses one by one, so the sustained
// request rate is one per clock as long as the average response count stays at
// one or below and rsp_stall stays low; bursts above that are absorbed by the
// queue, and req_stall rises only when the queue is full.

module shell_word_tokenizer
   import swt_pkg::*;
#(
   parameter int QUEUE_DEPTH = SWT_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_in_char,
   input  wire logic       req_line_end,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [2:0] rsp_token_kind,
   output      logic [7:0] rsp_out_char,
   output      logic       rsp_last
);

   logic             accept;
   logic             push;
   logic             pop;
   bundle_type       push_bundle;
   bundle_type       head_bundle;
   queue_status_type status;

   // Hold requests off only while the queue has no room for a bundle
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   // Front: classify the character and advance the scan mode
   swt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_char     (req_in_char),
      .line_end    (req_line_end),
      .push        (push),
      .push_bundle (push_bundle)
   );

   // Bundle queue between front and back
   swt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head_bundle (head_bundle),
      .status      (status)
   );

   // Back: serialize each bundle into response items
   swt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_bundle    (head_bundle),
      .status         (status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_kind (rsp_token_kind),
      .rsp_out_char   (rsp_out_char),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ----- design/swt_checker.sv -----
`default_nettype none

module swt_checker
   import swt_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_in_char,
   input wire logic       req_line_end,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_token_kind,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_last
);

   // Nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_token_kind) && $stable(rsp_out_char) &&
         $stable(rsp_last))
      else $error("stalled response changed");

   // Only word characters carry a character
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_CHAR |-> rsp_out_char == 8'h00)
      else $error("non-character token carries a character");

   // End of line always closes its request's responses
   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_EOL |-> rsp_last)
      else $error("end of line not flagged last");

   // The rest of a request's responses follow without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside one request's responses");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (.*);

`default_nettype wire
